FILE: rtl/nsmt_pkg.sv
// Package for the nested scope marker tracker.
// Holds request and result codes, the ring entry layout and default sizes.
// No dependencies.
package nsmt_pkg;

	localparam int ID_W = 32;
	localparam int TAG_W = 16;
	localparam int FLAG_W = 3;
	localparam int DATA_W = 32;
	localparam int ADDR_W = 2;

	localparam int RING_DEPTH_DEF = 32;
	localparam int STACK_DEPTH_DEF = 16;

	localparam int FLAG_BEGIN = 0;
	localparam int FLAG_END = 1;
	localparam int FLAG_PARENT = 2;

	localparam logic [ADDR_W-1:0] REG_FROZEN = 2'd0;

	typedef enum logic [1:0] {
		REQ_BEGIN = 2'd0,
		REQ_END = 2'd1,
		REQ_MARKER = 2'd2,
		REQ_CAPTURE = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		KIND_NEW = 2'd0,
		KIND_DONE = 2'd1,
		KIND_OPEN = 2'd2
	} kind_t;

	typedef struct packed {
		logic [ID_W-1:0] id;
		logic [TAG_W-1:0] tag;
		logic [ID_W-1:0] parent;
		logic [FLAG_W-1:0] flags;
	} ring_entry_t;

	localparam int RING_W = $bits(ring_entry_t);

	typedef struct packed {
		kind_t kind;
		logic [ID_W-1:0] id;
		logic [TAG_W-1:0] tag;
		logic found;
		logic full;
	} result_t;

endpackage

FILE: rtl/nsmt_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module nsmt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input logic clk,
	input logic we,
	input logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: rtl/nested_scope_marker_tracker.sv
// Nested scope marker tracker top level.
// Depends on nsmt_pkg and nsmt_ram.
//
// An item is taken when start is high and busy is low; busy then stays high
// until the item is finished, but a frozen begin or end, an end on an empty
// stack and a marker on an empty ring leave busy low. Results appear on the
// result ports with result_valid high for one cycle each; the receiver cannot
// stall them. A begin item reads the stack top in S_BEG_RD and writes its ring
// entry in S_BEG_WR, which loads its new id into the result register. When
// frozen, it keeps busy low and its id is loaded into the result register
// straight from S_IDLE. An end item searches the open stack from the top,
// then shifts the entries above the match down. A marker item searches the
// ring oldest first. A capture item scans the ring for the newest ended scope,
// then scans every entry and walks the ancestors of each begun, unended one
// by ring searches, then emits the marked entries. Its results are one for
// the newest ended scope, then one per marked entry; last_of_run flags the last.
// Every step is bounded by the single read port of the ring and stack memories.
// Reset clears the id counter, ring and stack counts and the frozen register;
// the memories need no clearing pass.
module nested_scope_marker_tracker #(
	parameter int RING_DEPTH = nsmt_pkg::RING_DEPTH_DEF,
	parameter int STACK_DEPTH = nsmt_pkg::STACK_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [nsmt_pkg::ADDR_W-1:0] paddr,
	input logic [nsmt_pkg::DATA_W-1:0] pwdata,
	output logic [nsmt_pkg::DATA_W-1:0] prdata,
	output logic pready,
	input logic start,
	output logic busy,
	input logic [1:0] req_type,
	input logic [nsmt_pkg::ID_W-1:0] scope_token,
	input logic marker_is_begin,
	input logic [nsmt_pkg::TAG_W-1:0] name_tag,
	output logic result_valid,
	output logic [1:0] record_kind,
	output logic [nsmt_pkg::ID_W-1:0] scope_id,
	output logic [nsmt_pkg::TAG_W-1:0] scope_tag,
	output logic found,
	output logic stack_full,
	output logic last_of_run
);
	import nsmt_pkg::*;

	localparam int RAW = RING_DEPTH > 1 ? $clog2(RING_DEPTH) : 1;
	localparam int CW = $clog2(RING_DEPTH + 1);
	localparam int SAW = STACK_DEPTH > 1 ? $clog2(STACK_DEPTH) : 1;
	localparam int SCW = $clog2(STACK_DEPTH + 1);
	localparam logic [CW:0] RING_DEPTH_W = (CW + 1)'(RING_DEPTH);
	localparam logic [CW-1:0] RING_FULL = CW'(RING_DEPTH);
	localparam logic [SCW-1:0] STACK_FULL = SCW'(STACK_DEPTH);

	typedef enum logic [18:0] {
		S_IDLE = 19'h00001,
		S_BEG_RD = 19'h00002,
		S_BEG_WR = 19'h00004,
		S_END_RD = 19'h00008,
		S_END_CHK = 19'h00010,
		S_SH_RD = 19'h00020,
		S_SH_WR = 19'h00040,
		S_MK_RD = 19'h00080,
		S_MK_CHK = 19'h00100,
		S_LC_RD = 19'h00200,
		S_LC_CHK = 19'h00400,
		S_SC_RD = 19'h00800,
		S_SC_CHK = 19'h01000,
		S_WK_RD = 19'h02000,
		S_WK_CHK = 19'h04000,
		S_EM_SEL = 19'h08000,
		S_EM_RD = 19'h10000,
		S_EM_CHK = 19'h20000,
		S_FLUSH = 19'h40000
	} state_t;

	function automatic logic [RAW-1:0] slot_of(input logic [RAW-1:0] h,
			input logic [CW-1:0] l);
		logic [CW:0] s;
		s = (CW + 1)'(h) + (CW + 1)'(l);
		if (s >= RING_DEPTH_W) begin
			s = s - RING_DEPTH_W;
		end
		return s[RAW-1:0];
	endfunction

	state_t state_q;
	logic frozen_q;
	logic [ID_W-1:0] next_id_q;
	logic [RAW-1:0] head_q;
	logic [CW-1:0] ring_cnt_q;
	logic [SCW-1:0] stk_cnt_q;
	logic [ID_W-1:0] tok_q;
	logic isb_q;
	logic [TAG_W-1:0] tag_q;
	logic [CW-1:0] lidx_q;
	logic [CW-1:0] cap_i_q;
	logic [CW-1:0] steps_q;
	logic [ID_W-1:0] par_q;
	logic [SCW-1:0] stk_i_q;
	logic [SAW-1:0] stk_idx_q;
	logic [RING_DEPTH-1:0] marks_q;

	result_t pend_q;
	logic pend_v_q;
	result_t out_q;
	logic out_v_q;
	logic out_last_q;

	logic ring_we;
	logic [RAW-1:0] ring_waddr;
	ring_entry_t ring_wentry;
	logic [RING_W-1:0] ring_rdata;
	ring_entry_t ring_rd;
	logic stk_we;
	logic [SAW-1:0] stk_waddr;
	logic [ID_W-1:0] stk_wdata;
	logic [ID_W-1:0] stk_rdata;

	logic accept;
	logic cfg_wr;
	logic stk_room;
	logic [CW-1:0] lidx_nx;
	logic [CW-1:0] cap_i_nx;
	logic [CW-1:0] steps_nx;
	logic [SCW-1:0] stk_i_p1;
	logic [SCW-1:0] stk_i_p2;
	logic [RAW-1:0] beg_slot;
	logic id_hit;
	logic direct_en;
	logic push_en;
	result_t push_res;

	assign accept = start && (state_q == S_IDLE);
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;
	assign prdata = (paddr == REG_FROZEN) ? DATA_W'(frozen_q) : '0;
	assign busy = (state_q != S_IDLE);

	assign ring_rd = ring_entry_t'(ring_rdata);
	assign stk_room = stk_cnt_q < STACK_FULL;
	assign lidx_nx = lidx_q + 1'b1;
	assign cap_i_nx = cap_i_q + 1'b1;
	assign steps_nx = steps_q + 1'b1;
	assign stk_i_p1 = stk_i_q + 1'b1;
	assign stk_i_p2 = stk_i_q + SCW'(2);
	assign beg_slot = (ring_cnt_q < RING_FULL) ? slot_of(head_q, ring_cnt_q) : head_q;
	assign id_hit = (ring_rd.id == tok_q);

	nsmt_ram #(
		.WIDTH(RING_W),
		.DEPTH(RING_DEPTH)
	) u_ring (
		.clk(clk),
		.we(ring_we),
		.waddr(ring_waddr),
		.wdata(ring_wentry),
		.raddr(slot_of(head_q, lidx_q)),
		.rdata(ring_rdata)
	);

	nsmt_ram #(
		.WIDTH(ID_W),
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk(clk),
		.we(stk_we),
		.waddr(stk_waddr),
		.wdata(stk_wdata),
		.raddr(stk_idx_q),
		.rdata(stk_rdata)
	);

	always_comb begin
		ring_we = 1'b0;
		ring_waddr = beg_slot;
		ring_wentry = ring_rd;
		stk_we = 1'b0;
		stk_waddr = stk_cnt_q[SAW-1:0];
		stk_wdata = next_id_q;
		case (state_q)
			S_BEG_WR: begin
				ring_we = 1'b1;
				ring_wentry.id = next_id_q;
				ring_wentry.tag = tag_q;
				ring_wentry.parent = (stk_cnt_q != '0) ? stk_rdata : '0;
				ring_wentry.flags = '0;
				ring_wentry.flags[FLAG_PARENT] = (stk_cnt_q != '0);
				stk_we = stk_room;
			end
			S_SH_WR: begin
				stk_we = 1'b1;
				stk_waddr = stk_i_q[SAW-1:0];
				stk_wdata = stk_rdata;
			end
			S_MK_CHK: begin
				ring_we = id_hit;
				ring_waddr = slot_of(head_q, lidx_q);
				if (isb_q) begin
					ring_wentry.flags[FLAG_BEGIN] = 1'b1;
				end else begin
					ring_wentry.flags[FLAG_END] = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		direct_en = 1'b0;
		push_en = 1'b0;
		push_res.kind = KIND_DONE;
		push_res.id = '0;
		push_res.tag = '0;
		push_res.found = 1'b0;
		push_res.full = 1'b0;
		case (state_q)
			S_IDLE: begin
				direct_en = accept && (req_type == REQ_BEGIN) && frozen_q;
				push_en = accept && (req_type == REQ_CAPTURE) && (ring_cnt_q == '0);
			end
			S_BEG_WR: begin
				direct_en = 1'b1;
			end
			S_LC_CHK: begin
				push_en = ring_rd.flags[FLAG_END] || (lidx_q == '0);
				if (ring_rd.flags[FLAG_END]) begin
					push_res.id = ring_rd.id;
					push_res.tag = ring_rd.tag;
					push_res.found = 1'b1;
				end
			end
			S_EM_CHK: begin
				push_en = 1'b1;
				push_res.kind = KIND_OPEN;
				push_res.id = ring_rd.id;
				push_res.tag = ring_rd.tag;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			out_last_q <= 1'b0;
			pend_v_q <= 1'b0;
		end else begin
			out_v_q <= direct_en || (state_q == S_FLUSH) || (push_en && pend_v_q);
			if (direct_en) begin
				out_last_q <= 1'b1;
				out_q.kind <= KIND_NEW;
				out_q.id <= next_id_q;
				out_q.tag <= '0;
				out_q.found <= 1'b0;
				out_q.full <= (state_q == S_BEG_WR) && !stk_room;
			end else if (state_q == S_FLUSH) begin
				out_last_q <= 1'b1;
				out_q <= pend_q;
				pend_v_q <= 1'b0;
			end else if (push_en) begin
				if (pend_v_q) begin
					out_last_q <= 1'b0;
					out_q <= pend_q;
				end
				pend_q <= push_res;
				pend_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frozen_q <= 1'b0;
		end else if (cfg_wr && (paddr == REG_FROZEN)) begin
			frozen_q <= pwdata[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			next_id_q <= '0;
			head_q <= '0;
			ring_cnt_q <= '0;
			stk_cnt_q <= '0;
			marks_q <= '0;
			lidx_q <= '0;
			cap_i_q <= '0;
			steps_q <= '0;
			stk_i_q <= '0;
			stk_idx_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						tok_q <= scope_token;
						isb_q <= marker_is_begin;
						tag_q <= name_tag;
						case (req_type)
							REQ_BEGIN: begin
								if (frozen_q) begin
									next_id_q <= next_id_q + 1'b1;
								end else begin
									stk_idx_q <= SAW'(stk_cnt_q - 1'b1);
									state_q <= S_BEG_RD;
								end
							end
							REQ_END: begin
								if (!frozen_q && (stk_cnt_q != '0)) begin
									stk_i_q <= stk_cnt_q - 1'b1;
									stk_idx_q <= SAW'(stk_cnt_q - 1'b1);
									state_q <= S_END_RD;
								end
							end
							REQ_MARKER: begin
								if (ring_cnt_q != '0) begin
									lidx_q <= '0;
									state_q <= S_MK_RD;
								end
							end
							REQ_CAPTURE: begin
								if (ring_cnt_q != '0) begin
									lidx_q <= ring_cnt_q - 1'b1;
									state_q <= S_LC_RD;
								end else begin
									state_q <= S_FLUSH;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_BEG_RD: begin
					state_q <= S_BEG_WR;
				end
				S_BEG_WR: begin
					next_id_q <= next_id_q + 1'b1;
					if (stk_room) begin
						stk_cnt_q <= stk_cnt_q + 1'b1;
					end
					if (ring_cnt_q < RING_FULL) begin
						ring_cnt_q <= ring_cnt_q + 1'b1;
					end else begin
						head_q <= slot_of(head_q, CW'(1));
					end
					state_q <= S_IDLE;
				end
				S_END_RD: begin
					state_q <= S_END_CHK;
				end
				S_END_CHK: begin
					if (stk_rdata == tok_q) begin
						if (stk_i_p1 < stk_cnt_q) begin
							stk_idx_q <= stk_i_p1[SAW-1:0];
							state_q <= S_SH_RD;
						end else begin
							stk_cnt_q <= stk_cnt_q - 1'b1;
							state_q <= S_IDLE;
						end
					end else if (stk_i_q == '0) begin
						state_q <= S_IDLE;
					end else begin
						stk_i_q <= stk_i_q - 1'b1;
						stk_idx_q <= SAW'(stk_i_q - 1'b1);
						state_q <= S_END_RD;
					end
				end
				S_SH_RD: begin
					state_q <= S_SH_WR;
				end
				S_SH_WR: begin
					stk_i_q <= stk_i_p1;
					if (stk_i_p2 < stk_cnt_q) begin
						stk_idx_q <= stk_i_p2[SAW-1:0];
						state_q <= S_SH_RD;
					end else begin
						stk_cnt_q <= stk_cnt_q - 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_MK_RD: begin
					state_q <= S_MK_CHK;
				end
				S_MK_CHK: begin
					if (!id_hit && (lidx_nx < ring_cnt_q)) begin
						lidx_q <= lidx_nx;
						state_q <= S_MK_RD;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_LC_RD: begin
					state_q <= S_LC_CHK;
				end
				S_LC_CHK: begin
					if (ring_rd.flags[FLAG_END] || (lidx_q == '0)) begin
						marks_q <= '0;
						cap_i_q <= '0;
						lidx_q <= '0;
						state_q <= S_SC_RD;
					end else begin
						lidx_q <= lidx_q - 1'b1;
						state_q <= S_LC_RD;
					end
				end
				S_SC_RD: begin
					state_q <= S_SC_CHK;
				end
				S_SC_CHK: begin
					if (ring_rd.flags[FLAG_BEGIN] && !ring_rd.flags[FLAG_END]) begin
						marks_q[cap_i_q[RAW-1:0]] <= 1'b1;
					end
					if (ring_rd.flags[FLAG_BEGIN] && !ring_rd.flags[FLAG_END]
							&& ring_rd.flags[FLAG_PARENT]) begin
						par_q <= ring_rd.parent;
						steps_q <= '0;
						lidx_q <= '0;
						state_q <= S_WK_RD;
					end else if (cap_i_nx < ring_cnt_q) begin
						cap_i_q <= cap_i_nx;
						lidx_q <= cap_i_nx;
						state_q <= S_SC_RD;
					end else begin
						cap_i_q <= '0;
						state_q <= S_EM_SEL;
					end
				end
				S_WK_RD: begin
					state_q <= S_WK_CHK;
				end
				S_WK_CHK: begin
					if (ring_rd.id == par_q) begin
						if (!ring_rd.flags[FLAG_END]) begin
							marks_q[lidx_q[RAW-1:0]] <= 1'b1;
						end
						par_q <= ring_rd.parent;
						steps_q <= steps_nx;
					end
					if ((ring_rd.id == par_q) && ring_rd.flags[FLAG_PARENT]
							&& (steps_nx < RING_FULL)) begin
						lidx_q <= '0;
						state_q <= S_WK_RD;
					end else if ((ring_rd.id != par_q) && (lidx_nx < ring_cnt_q)) begin
						lidx_q <= lidx_nx;
						state_q <= S_WK_RD;
					end else if (cap_i_nx < ring_cnt_q) begin
						cap_i_q <= cap_i_nx;
						lidx_q <= cap_i_nx;
						state_q <= S_SC_RD;
					end else begin
						cap_i_q <= '0;
						state_q <= S_EM_SEL;
					end
				end
				S_EM_SEL: begin
					if (cap_i_q >= ring_cnt_q) begin
						state_q <= S_FLUSH;
					end else if (marks_q[cap_i_q[RAW-1:0]]) begin
						lidx_q <= cap_i_q;
						state_q <= S_EM_RD;
					end else begin
						cap_i_q <= cap_i_nx;
					end
				end
				S_EM_RD: begin
					state_q <= S_EM_CHK;
				end
				S_EM_CHK: begin
					cap_i_q <= cap_i_nx;
					state_q <= S_EM_SEL;
				end
				S_FLUSH: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign result_valid = out_v_q;
	assign record_kind = out_q.kind;
	assign scope_id = out_q.id;
	assign scope_tag = out_q.tag;
	assign found = out_q.found;
	assign stack_full = out_q.full;
	assign last_of_run = out_last_q;

`ifndef ASSERT_OFF
	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !pend_v_q)
		else $error("Pending result held while idle.");
	a_ring_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		ring_cnt_q <= RING_FULL)
		else $error("Ring count beyond depth.");
	a_stack_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		stk_cnt_q <= STACK_FULL)
		else $error("Stack count beyond depth.");
	a_new_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && (out_q.kind == KIND_NEW)) |-> out_last_q)
		else $error("Begin result not marked last.");
	a_flush_sends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FLUSH) |=> (out_v_q && out_last_q))
		else $error("Capture ended without a final result.");
`endif
endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for the nested scope marker tracker.
// Depends on nsmt_pkg and the nested_scope_marker_tracker RTL; an internal
// predictor computes the expected result items of every accepted item.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import nsmt_pkg::*;

	localparam int RING_N = RING_DEPTH_DEF;
	localparam int STACK_N = STACK_DEPTH_DEF;
	localparam longint CYCLE_LIMIT = 100000000;
	localparam int DRAIN_CYCLES = 200;

	typedef struct {
		kind_t kind;
		logic [ID_W-1:0] id;
		logic [TAG_W-1:0] tag;
		logic found;
		logic full;
		logic last;
	} scope_result_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic pready;
	logic start;
	logic busy;
	logic [1:0] req_type;
	logic [ID_W-1:0] scope_token;
	logic marker_is_begin;
	logic [TAG_W-1:0] name_tag;
	logic result_valid;
	logic [1:0] record_kind;
	logic [ID_W-1:0] scope_id;
	logic [TAG_W-1:0] scope_tag;
	logic found, stack_full, last_of_run;

	nested_scope_marker_tracker dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.start(start), .busy(busy),
		.req_type(req_type), .scope_token(scope_token),
		.marker_is_begin(marker_is_begin), .name_tag(name_tag),
		.result_valid(result_valid), .record_kind(record_kind),
		.scope_id(scope_id), .scope_tag(scope_tag), .found(found),
		.stack_full(stack_full), .last_of_run(last_of_run)
	);

	// Tracker state as the testbench expects it.
	logic model_frozen;
	logic [ID_W-1:0] model_next_id;
	logic [ID_W-1:0] ring_id [RING_N];
	logic [TAG_W-1:0] ring_tag [RING_N];
	logic [ID_W-1:0] ring_parent [RING_N];
	logic [FLAG_W-1:0] ring_flag [RING_N];
	int ring_head, ring_used;
	logic [ID_W-1:0] open_ids [STACK_N];
	int open_used;

	scope_result_t pending_results [$];
	logic [ID_W-1:0] issued_ids [$];
	int error_count = 0;
	longint cycle_count = 0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL nested_scope_marker_tracker");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		$display("mismatch at cycle %0d: %s", cycle_count, msg);
		error_count++;
	endtask

	function automatic int slot_at(input int logical);
		return (ring_head + logical) % RING_N;
	endfunction

	function automatic int oldest_with_id(input logic [ID_W-1:0] id);
		for (int i = 0; i < ring_used; i++)
			if (ring_id[slot_at(i)] == id)
				return i;
		return ring_used;
	endfunction

	function automatic void push_result(input kind_t k, input logic [ID_W-1:0] id,
			input logic [TAG_W-1:0] tg, input logic fnd, input logic full);
		scope_result_t r;
		r.kind = k;
		r.id = id;
		r.tag = tg;
		r.found = fnd;
		r.full = full;
		r.last = 1'b0;
		pending_results.insert(pending_results.size(), r);
	endfunction

	function automatic void track_item(input req_t rq, input logic [ID_W-1:0] tok,
			input logic mib, input logic [TAG_W-1:0] tg);
		logic [ID_W-1:0] id;
		logic full;
		int s, pl;
		logic [FLAG_W-1:0] fl;
		logic marks [RING_N];
		case (rq)
			REQ_BEGIN: begin
				id = model_next_id;
				model_next_id = model_next_id + 1'b1;
				full = 1'b0;
				issued_ids.insert(issued_ids.size(), id);
				if (issued_ids.size() > 40)
					void'(issued_ids.pop_front());
				if (!model_frozen) begin
					fl = '0;
					if (open_used > 0)
						fl[FLAG_PARENT] = 1'b1;
					if (ring_used < RING_N) begin
						s = slot_at(ring_used);
						ring_used++;
					end else begin
						s = ring_head;
						ring_head = (ring_head + 1) % RING_N;
					end
					ring_id[s] = id;
					ring_tag[s] = tg;
					ring_parent[s] = (open_used > 0) ? open_ids[open_used-1] : '0;
					ring_flag[s] = fl;
					if (open_used < STACK_N)
						open_ids[open_used++] = id;
					else
						full = 1'b1;
				end
				push_result(KIND_NEW, id, '0, 1'b0, full);
			end
			REQ_END: begin
				if (!model_frozen) begin
					for (int i = open_used - 1; i >= 0; i--) begin
						if (open_ids[i] == tok) begin
							for (int j = i; j + 1 < open_used; j++)
								open_ids[j] = open_ids[j+1];
							open_used--;
							break;
						end
					end
				end
			end
			REQ_MARKER: begin
				pl = oldest_with_id(tok);
				if (pl < ring_used)
					ring_flag[slot_at(pl)][mib ? FLAG_BEGIN : FLAG_END] = 1'b1;
			end
			default: begin
				pl = -1;
				for (int i = ring_used - 1; i >= 0; i--) begin
					if (ring_flag[slot_at(i)][FLAG_END]) begin
						pl = i;
						break;
					end
				end
				if (pl >= 0)
					push_result(KIND_DONE, ring_id[slot_at(pl)], ring_tag[slot_at(pl)],
						1'b1, 1'b0);
				else
					push_result(KIND_DONE, '0, '0, 1'b0, 1'b0);
				for (int i = 0; i < RING_N; i++)
					marks[i] = 1'b0;
				for (int i = 0; i < ring_used; i++) begin
					s = slot_at(i);
					fl = ring_flag[s];
					if (!fl[FLAG_BEGIN] || fl[FLAG_END])
						continue;
					marks[i] = 1'b1;
					for (int n = 0; n < RING_N && fl[FLAG_PARENT]; n++) begin
						pl = oldest_with_id(ring_parent[s]);
						if (pl >= ring_used)
							break;
						s = slot_at(pl);
						fl = ring_flag[s];
						if (!fl[FLAG_END])
							marks[pl] = 1'b1;
					end
				end
				for (int i = 0; i < ring_used; i++)
					if (marks[i])
						push_result(KIND_OPEN, ring_id[slot_at(i)], ring_tag[slot_at(i)],
							1'b0, 1'b0);
			end
		endcase
		if (rq == REQ_BEGIN || rq == REQ_CAPTURE)
			pending_results[pending_results.size()-1].last = 1'b1;
	endfunction

	always @(posedge clk) begin
		scope_result_t r;
		if (arst_n && result_valid) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result kind %0d id %0h",
					record_kind, scope_id));
			end else begin
				r = pending_results.pop_front();
				if (record_kind !== r.kind)
					report_mismatch($sformatf("record_kind %0d, want %0d", record_kind, r.kind));
				if (scope_id !== r.id)
					report_mismatch($sformatf("scope_id %0h, want %0h", scope_id, r.id));
				if (scope_tag !== r.tag)
					report_mismatch($sformatf("scope_tag %0h, want %0h", scope_tag, r.tag));
				if (found !== r.found)
					report_mismatch($sformatf("found %0b, want %0b", found, r.found));
				if (stack_full !== r.full)
					report_mismatch($sformatf("stack_full %0b, want %0b", stack_full, r.full));
				if (last_of_run !== r.last)
					report_mismatch($sformatf("last_of_run %0b, want %0b", last_of_run, r.last));
			end
		end
	end

	task automatic send_item(input req_t rq, input logic [ID_W-1:0] tok,
			input logic mib, input logic [TAG_W-1:0] tg);
		int gap;
		gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req_type <= rq;
		scope_token <= tok;
		marker_is_begin <= mib;
		name_tag <= tg;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		track_item(rq, tok, mib, tg);
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic write_frozen(input logic v);
		wait_idle();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= REG_FROZEN;
		pwdata <= {{(DATA_W-1){1'b0}}, v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		model_frozen = v;
	endtask

	function automatic logic [ID_W-1:0] known_id();
		if (issued_ids.size() == 0)
			return '0;
		return issued_ids[$urandom_range(0, issued_ids.size() - 1)];
	endfunction

	task automatic test_nesting();
		send_item(REQ_CAPTURE, '0, 1'b0, '0);
		for (int i = 0; i < 17; i++)
			send_item(REQ_BEGIN, '0, 1'b0,
				(i == 0) ? 16'h0000 : (i == 1) ? 16'hFFFF : TAG_W'(i));
		send_item(REQ_MARKER, 32'd3, 1'b1, '0);
		send_item(REQ_MARKER, 32'd2, 1'b0, '0);
		send_item(REQ_MARKER, 32'd16, 1'b1, '0);
		send_item(REQ_END, 32'd5, 1'b0, '0);
		send_item(REQ_END, 32'hFFFF_FFFF, 1'b1, 16'hFFFF);
		send_item(REQ_MARKER, 32'hFFFF_FFFF, 1'b0, '0);
		send_item(REQ_CAPTURE, '0, 1'b0, '0);
	endtask

	task automatic test_frozen();
		write_frozen(1'b1);
		send_item(REQ_BEGIN, '0, 1'b0, 16'hABCD);
		send_item(REQ_END, 32'd16, 1'b0, '0);
		send_item(REQ_MARKER, 32'd4, 1'b0, '0);
		send_item(REQ_CAPTURE, '0, 1'b0, '0);
		write_frozen(1'b0);
	endtask

	task automatic test_random(input int count);
		int pick;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 35)
				send_item(REQ_BEGIN, $urandom, 1'($urandom_range(0, 1)),
					TAG_W'($urandom_range(0, 65535)));
			else if (pick < 55)
				send_item(REQ_END, known_id(), 1'($urandom_range(0, 1)),
					TAG_W'($urandom_range(0, 65535)));
			else if (pick < 85)
				send_item(REQ_MARKER, known_id(), $urandom_range(0, 3) != 0,
					TAG_W'($urandom_range(0, 65535)));
			else if (pick < 92)
				send_item(($urandom_range(0, 1) != 0) ? REQ_END : REQ_MARKER, $urandom,
					1'($urandom_range(0, 1)), TAG_W'($urandom_range(0, 65535)));
			else
				send_item(REQ_CAPTURE, $urandom, 1'($urandom_range(0, 1)),
					TAG_W'($urandom_range(0, 65535)));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		start = 1'b0;
		req_type = '0;
		scope_token = '0;
		marker_is_begin = 1'b0;
		name_tag = '0;
		model_frozen = 1'b0;
		model_next_id = '0;
		ring_head = 0;
		ring_used = 0;
		open_used = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_nesting();
		test_frozen();
		test_random(120);
		write_frozen(1'b1);
		test_random(30);
		write_frozen(1'b0);
		test_random(100);

		wait_idle();
		if (error_count == 0)
			$display("PASS nested_scope_marker_tracker");
		else
			$display("FAIL nested_scope_marker_tracker");
		$finish;
	end

endmodule
